@@ rtl/nss_pkg.sv @@
// nss_pkg: shared types and constants for the nearest sample select block
// item structs, command codes, back-end state encoding
// no dependencies
`default_nettype none

package nss_pkg;

  localparam int unsigned POS_W  = 24;
  localparam int unsigned HGT_W  = 32;
  localparam int unsigned DIST_W = 25;
  localparam int unsigned LCNT_W = 11;
  localparam int unsigned RANK_W = 4;
  localparam int unsigned CFG_W  = 5;
  localparam int unsigned CMD_W  = 2;

  // planar distance arithmetic
  localparam int unsigned DX_W   = 24;   // |a - b| of two 24-bit signed values
  localparam int unsigned SQ_W   = 48;
  localparam int unsigned D2_W   = 49;
  localparam int unsigned SQ_TOP = 48;   // highest even bit of a squared distance

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic signed [POS_W-1:0] pos_east;
    logic signed [POS_W-1:0] pos_north;
    logic signed [HGT_W-1:0] height;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]       rank;
    logic                    found;
    logic signed [POS_W-1:0] sample_east;
    logic signed [POS_W-1:0] sample_north;
    logic signed [HGT_W-1:0] sample_height;
    logic [DIST_W-1:0]       distance;
    logic [LCNT_W-1:0]       loaded_count;
    logic                    overflow;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic signed [POS_W-1:0] east;
    logic signed [POS_W-1:0] north;
    logic signed [HGT_W-1:0] height;
  } point_t;

  typedef struct packed {
    logic signed [POS_W-1:0] tgt_east;
    logic signed [POS_W-1:0] tgt_north;
    logic                    overflow;
  } query_t;

endpackage

`default_nettype wire

@@ rtl/nss_ram.sv @@
// nss_ram: generic single write port, single read port ram
// registered read data; no dependencies
`default_nettype none

module nss_ram #(
  parameter int unsigned WIDTH = 80,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ rtl/nss_fifo.sv @@
// nss_fifo: small register fifo for items between stages
// no dependencies
`default_nettype none

module nss_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] rdata_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, rd_q;
  logic [CW-1:0]    cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/nss_front.sv @@
// nss_front: accepts items, appends points to the store, queues queries
// depends on nss_pkg and nss_fifo
`default_nettype none

module nss_front #(
  parameter int unsigned MAX_POINTS = 1024,
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int unsigned CW = $clog2(MAX_POINTS + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire nss_pkg::in_item_t item_i,
  output logic                   full_o,
  input  wire logic              back_busy_i,
  output logic                   we_o,
  output logic [AW-1:0]          waddr_o,
  output nss_pkg::point_t        wdata_o,
  output logic                   q_valid_o,
  output nss_pkg::query_t        q_item_o,
  output logic [CW-1:0]          q_count_o,
  input  wire logic              q_pop_i
);

  import nss_pkg::*;

  localparam int unsigned QW = $bits(query_t) + CW;

  logic [CW-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          acc, q_full, q_empty, q_push;
  logic [QW-1:0] q_wdata, q_rdata;
  query_t        q_new;

  // a clear waits until every earlier query has finished reading the store
  assign full_o = (item_i.command == CMD_QUERY && q_full) ||
                  (item_i.command == CMD_CLEAR && (back_busy_i || !q_empty));
  assign acc    = push_i && !full_o;

  assign we_o    = acc && item_i.command == CMD_LOAD && count_q < CW'(MAX_POINTS);
  assign waddr_o = count_q[AW-1:0];
  assign wdata_o = '{east: item_i.pos_east, north: item_i.pos_north,
                     height: item_i.height};

  assign q_push  = acc && item_i.command == CMD_QUERY;
  assign q_new   = '{tgt_east: item_i.pos_east, tgt_north: item_i.pos_north,
                     overflow: ovf_q};
  assign q_wdata = {q_new, count_q};

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    if (acc) begin
      case (item_i.command)
        CMD_LOAD: begin
          if (count_q < CW'(MAX_POINTS)) begin
            count_d = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        CMD_CLEAR: count_d = '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  nss_fifo #(
    .WIDTH (QW),
    .DEPTH (2)
  ) u_query_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop_i),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  assign q_valid_o = !q_empty;
  assign q_item_o  = q_rdata[QW-1:CW];
  assign q_count_o = q_rdata[CW-1:0];

endmodule

`default_nettype wire

@@ rtl/nss_back.sv @@
// nss_back: scans the store for a query, keeps a ranked list, takes roots, emits items
// depends on nss_pkg
`default_nettype none

module nss_back #(
  parameter int unsigned MAX_POINTS    = 1024,
  parameter int unsigned MAX_NEIGHBORS = 16,
  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1,
  localparam int unsigned CW = $clog2(MAX_POINTS + 1),
  localparam int unsigned NW = $clog2(MAX_NEIGHBORS + 1),
  localparam int unsigned JW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [nss_pkg::CFG_W-1:0]  cfg_count_i,
  input  wire logic                       q_valid_i,
  input  wire nss_pkg::query_t            q_item_i,
  input  wire logic [CW-1:0]              q_count_i,
  output logic                            q_pop_o,
  output logic [AW-1:0]                   raddr_o,
  input  wire nss_pkg::point_t            rdata_i,
  input  wire logic                       res_full_i,
  output logic                            res_push_o,
  output nss_pkg::out_item_t              res_item_o,
  output logic                            busy_o
);

  import nss_pkg::*;

  back_state_e state_q, state_d;

  logic signed [POS_W-1:0] tgt_e_q, tgt_n_q;
  logic [CW-1:0]           cnt_q, i_q;
  logic                    ovf_q, nf_q;
  logic [NW-1:0]           n_q, j_q, kc;

  logic                    va_q, vb_q, vc_q, vd_q;
  logic [AW-1:0]           ia_q, ib_q, ic_q, id_q;
  logic [DX_W-1:0]         dx_q, dy_q;
  logic [SQ_W-1:0]         sx_q, sy_q;
  logic [D2_W-1:0]         d2_q;

  logic [D2_W-1:0]         best_d2_q  [MAX_NEIGHBORS];
  logic [AW-1:0]           best_idx_q [MAX_NEIGHBORS];
  logic [D2_W-1:0]         best_d2_d  [MAX_NEIGHBORS];
  logic [AW-1:0]           best_idx_d [MAX_NEIGHBORS];
  logic [MAX_NEIGHBORS-1:0] gt;
  logic                    ins;

  logic [D2_W-1:0]         rem_q;
  logic [D2_W:0]           res_q, root_try;
  logic [D2_W-1:0]         root_bit_q;

  logic signed [POS_W:0]   de, dn;
  logic                    scan_end, drained, last_item;
  logic [NW-1:0]           j_nx;

  // clamp of the neighbor count register
  always_comb begin
    if (cfg_count_i == '0) begin
      kc = NW'(1);
    end else if (32'(cfg_count_i) > MAX_NEIGHBORS) begin
      kc = NW'(MAX_NEIGHBORS);
    end else begin
      kc = NW'(cfg_count_i);
    end
  end

  assign scan_end  = (i_q == cnt_q - CW'(1));
  assign drained   = !(va_q || vb_q || vc_q || vd_q);
  assign last_item = nf_q || (j_q == n_q - NW'(1));
  assign j_nx      = j_q + NW'(1);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          state_d = (q_count_i == '0) ? ST_DRAIN : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (drained) state_d = (n_q == '0) ? ST_EMIT : ST_ROOT;
      end
      ST_ROOT: begin
        if (root_bit_q == '0) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (!res_full_i) state_d = last_item ? ST_IDLE : ST_ROOT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop_o    = (state_q == ST_IDLE) && q_valid_i;
    busy_o     = (state_q != ST_IDLE);
    raddr_o    = (state_q == ST_SCAN) ? i_q[AW-1:0] : best_idx_q[j_q[JW-1:0]];
    res_push_o = (state_q == ST_EMIT) && !res_full_i;
    res_item_o.rank          = RANK_W'(j_q);
    res_item_o.found         = !nf_q;
    res_item_o.sample_east   = nf_q ? '0 : rdata_i.east;
    res_item_o.sample_north  = nf_q ? '0 : rdata_i.north;
    res_item_o.sample_height = nf_q ? '0 : rdata_i.height;
    res_item_o.distance      = nf_q ? '0 : res_q[DIST_W-1:0];
    res_item_o.loaded_count  = LCNT_W'(cnt_q);
    res_item_o.overflow      = ovf_q;
    res_item_o.last          = last_item;
  end

  // ranked insertion: entries farther than the candidate move down one place
  always_comb begin
    for (int unsigned j = 0; j < MAX_NEIGHBORS; j++) begin
      gt[j] = (NW'(j) < n_q) && (best_d2_q[j] > d2_q);
    end
    ins = vd_q && (d2_q != '0) && ((n_q < kc) || (|gt));
    for (int unsigned j = 0; j < MAX_NEIGHBORS; j++) begin
      best_d2_d[j]  = best_d2_q[j];
      best_idx_d[j] = best_idx_q[j];
      if (j > 0 && gt[(j > 0) ? j - 1 : 0]) begin
        best_d2_d[j]  = best_d2_q[(j > 0) ? j - 1 : 0];
        best_idx_d[j] = best_idx_q[(j > 0) ? j - 1 : 0];
      end else if (gt[j] || NW'(j) == n_q) begin
        best_d2_d[j]  = d2_q;
        best_idx_d[j] = id_q;
      end
    end
  end

  assign de       = {rdata_i.east[POS_W-1], rdata_i.east} - {tgt_e_q[POS_W-1], tgt_e_q};
  assign dn       = {rdata_i.north[POS_W-1], rdata_i.north} - {tgt_n_q[POS_W-1], tgt_n_q};
  assign root_try = res_q + {1'b0, root_bit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      vc_q    <= 1'b0;
      vd_q    <= 1'b0;
      n_q     <= '0;
      j_q     <= '0;
      nf_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      va_q    <= (state_q == ST_SCAN);
      vb_q    <= va_q;
      vc_q    <= vb_q;
      vd_q    <= vc_q;
      if (q_pop_o) begin
        n_q <= '0;
      end else if (ins && n_q < kc) begin
        n_q <= n_q + NW'(1);
      end
      if (state_q == ST_DRAIN && drained) begin
        j_q  <= '0;
        nf_q <= (n_q == '0);
      end else if (state_q == ST_EMIT && !res_full_i && !last_item) begin
        j_q <= j_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      tgt_e_q <= q_item_i.tgt_east;
      tgt_n_q <= q_item_i.tgt_north;
      ovf_q   <= q_item_i.overflow;
      cnt_q   <= q_count_i;
      i_q     <= '0;
    end else if (state_q == ST_SCAN) begin
      i_q <= i_q + CW'(1);
    end
    ia_q <= i_q[AW-1:0];
    ib_q <= ia_q;
    ic_q <= ib_q;
    id_q <= ic_q;
    dx_q <= de[POS_W] ? DX_W'(-de) : DX_W'(de);
    dy_q <= dn[POS_W] ? DX_W'(-dn) : DX_W'(dn);
    sx_q <= SQ_W'(dx_q) * SQ_W'(dx_q);
    sy_q <= SQ_W'(dy_q) * SQ_W'(dy_q);
    d2_q <= D2_W'(sx_q) + D2_W'(sy_q);
    if (ins) begin
      best_d2_q  <= best_d2_d;
      best_idx_q <= best_idx_d;
    end
    // digit-by-digit root, one result bit per cycle
    if (state_q == ST_DRAIN && drained) begin
      rem_q      <= best_d2_q[0];
      res_q      <= '0;
      root_bit_q <= D2_W'(1) << SQ_TOP;
    end else if (state_q == ST_EMIT && !res_full_i && !last_item) begin
      rem_q      <= best_d2_q[j_nx[JW-1:0]];
      res_q      <= '0;
      root_bit_q <= D2_W'(1) << SQ_TOP;
    end else if (state_q == ST_ROOT && root_bit_q != '0) begin
      if ({1'b0, rem_q} >= root_try) begin
        rem_q <= rem_q - D2_W'(root_try);
        res_q <= (res_q >> 1) + {1'b0, root_bit_q};
      end else begin
        res_q <= res_q >> 1;
      end
      root_bit_q <= root_bit_q >> 2;
    end
  end

endmodule

`default_nettype wire

@@ rtl/nearest_sample_select.sv @@
// a query over N stored points scans them one point per cycle through the store read
// port, drains the distance pipeline, then for each reported neighbor takes a bit-serial
// square root and reads the store, waiting while the result queue is full
// throughput: one load per cycle; a query can wait in the queue while another runs
// reset: asynchronous active low; point count and overflow clear, neighbor_count
// goes to 8, store contents stay undefined (no clearing pass)
`default_nettype none

module nearest_sample_select #(
  parameter int unsigned MAX_POINTS    = 1024,
  parameter int unsigned MAX_NEIGHBORS = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // item input, queue style
  input  wire logic                       push,
  input  wire nss_pkg::in_item_t          in_item_i,
  output logic                            full,
  // result output, queue style
  output logic                            empty,
  output nss_pkg::out_item_t              out_item_o,
  input  wire logic                       pop,
  // neighbor_count register write
  input  wire logic                       cfg_valid_i,
  input  wire logic [nss_pkg::CFG_W-1:0]  cfg_data_i,
  output logic                            cfg_ready_o
);

  import nss_pkg::*;

  localparam int unsigned AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  logic [CFG_W-1:0] cfg_q;

  // front to store and back
  logic             we;
  logic [AW-1:0]    waddr, raddr;
  point_t           wdata, rdata;
  logic             q_valid, q_pop, back_busy;
  query_t           q_item;
  logic [CW-1:0]    q_count;

  // back to result queue
  logic             res_push, res_full;
  out_item_t        res_item;

  // the register is always ready; the user must write it only while idle (not enforced here)
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // front: loads go straight into the store, queries wait in a two-entry queue
  nss_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (in_item_i),
    .full_o      (full),
    .back_busy_i (back_busy),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_count_o   (q_count),
    .q_pop_i     (q_pop)
  );

  // point store: east, north and height in one word
  nss_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // back: scan, rank, root, emit
  nss_back #(
    .MAX_POINTS    (MAX_POINTS),
    .MAX_NEIGHBORS (MAX_NEIGHBORS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_count_i (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_count_i   (q_count),
    .q_pop_o     (q_pop),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_item_o  (res_item),
    .busy_o      (back_busy)
  );

  // result queue decouples the back end from the consumer
  nss_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_item),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

`ifndef ASSERT_OFF
  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

  a_notfound_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.found) |-> out_item_o.last)
    else $error("not-found item is not the last of its query");

  a_found_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.found) |-> (out_item_o.distance != '0))
    else $error("reported neighbor at zero distance");
`endif

endmodule

`default_nettype wire
